### hdl/assert_macros.svh
// Assertion macros used by the RTL of the RTC timestamp converter.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_HOLD(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("Assertion failed.");

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed.");

`else

`define ASSERT_HOLD(label, clk, rst_n, expr)

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/rtc2unix_pkg.sv
// Types, constants and helper functions of the RTC timestamp converter.
// Depends on nothing; used by cmos_rtc_to_unix_time.
`default_nettype none

package rtc2unix_pkg;

    typedef struct packed {
        logic [7:0] raw_seconds;
        logic [7:0] raw_minutes;
        logic [7:0] raw_hours;
        logic [7:0] raw_day;
        logic [7:0] raw_month;
        logic [7:0] raw_year;
        logic [7:0] raw_century;
        logic       binary_mode;
        logic       mode_24h;
    } snap_t;

    typedef struct packed {
        logic [37:0] unix_seconds;
        logic [13:0] full_year;
        logic        before_epoch;
        logic        range_error;
    } result_t;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [0:0] REG_CENTURY_PRESENT = 1'b0;
    localparam logic [0:0] REG_PIVOT_YEAR      = 1'b1;

    localparam logic        CENTURY_PRESENT_RST = 1'b0;
    localparam logic [13:0] PIVOT_YEAR_RST      = 14'd2025;
    localparam logic [7:0]  PIVOT_CENTURY_RST   = 8'd20;

    localparam logic [14:0] EPOCH_YEAR          = 15'd1970;
    localparam logic [14:0] MAX_YEAR            = 15'd9999;
    localparam logic [21:0] LEAPS_BEFORE_EPOCH  = 22'd477;
    localparam logic [37:0] MAX_UNIX            = 38'd253402300799;
    localparam logic [16:0] SECS_PER_DAY        = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR       = 12'd3600;

    // floor(x / 100) == (x * 5243) >> 19 for every x below 2**14.
    localparam logic [12:0] RECIP_100           = 13'd5243;
    localparam int unsigned RECIP_SHIFT         = 19;

    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return 8'(b[3:0]) + 8'(b[7:4]) * 8'd10;
    endfunction

    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] days;
        case (idx)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            4'd11:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    function automatic logic [7:0] div100(input logic [13:0] x);
        logic [26:0] prod;
        prod = 27'(x) * 27'(RECIP_100);
        return 8'(prod >> RECIP_SHIFT);
    endfunction

endpackage

`default_nettype wire

### hdl/cmos_rtc_to_unix_time.sv
// Converts CMOS clock register snapshots into seconds since 1970 with year and error flags.
// Depends on rtc2unix_pkg and assert_macros.svh.
//
// One snapshot is taken per clock cycle unless the pipeline is stalled, and passes through
// an input register, a decode stage (BCD, 12-hour, full year), a stage holding the two
// divide-by-100 reciprocal multipliers, a day-count stage, and the output register after
// the days-to-seconds multiplier and saturation. Each stage moves on as soon as the one after
// it is free, so a stalled result stops only the stages behind it. There is no clearing pass
// after reset. The configuration port is APB-style with pready tied high; the century_present
// register sits at byte address 0 and pivot_year at byte address 4.
`default_nettype none
`include "assert_macros.svh"

module cmos_rtc_to_unix_time (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                snap_valid,
    output logic                                     snap_ready,
    input  wire rtc2unix_pkg::snap_t                 snap,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output rtc2unix_pkg::result_t                    result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rtc2unix_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [rtc2unix_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [rtc2unix_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                     pready
);

    import rtc2unix_pkg::*;

    localparam int unsigned NUM_STAGES = 5;

    typedef struct packed {
        logic [7:0]  sec;
        logic [7:0]  min;
        logic [7:0]  hr;
        logic [7:0]  day_off;
        logic [3:0]  mon_idx;
        logic        mon_gt2;
        logic [14:0] full;
        logic [13:0] year_out;
        logic        pre_epoch;
        logic        range_err;
    } decode_t;

    typedef struct packed {
        logic [7:0]  q_y;
        logic [7:0]  q_f;
        logic [13:0] y_m1;
        logic [19:0] tod;
        logic [7:0]  day_off;
        logic [3:0]  mon_idx;
        logic        mon_gt2;
        logic [14:0] full;
        logic [13:0] year_out;
        logic        pre_epoch;
        logic        range_err;
    } quot_t;

    typedef struct packed {
        logic [21:0] days;
        logic [19:0] tod;
        logic [13:0] year_out;
        logic        pre_epoch;
        logic        range_err;
    } days_t;

    logic                  century_present_reg;
    logic [13:0]           pivot_year_reg;
    logic [7:0]            pivot_century_reg;
    logic                  cfg_write;

    logic [NUM_STAGES-1:0] stage_valid_reg;
    logic [NUM_STAGES-1:0] stage_valid_next;
    logic [NUM_STAGES-1:0] stage_ready;

    snap_t                 snap_reg;
    decode_t               decode_reg;
    decode_t               decode_next;
    quot_t                 quot_reg;
    quot_t                 quot_next;
    days_t                 days_reg;
    days_t                 days_next;
    result_t               result_reg;
    result_t               result_next;

    logic [7:0]            sec_dec;
    logic [7:0]            min_dec;
    logic [7:0]            hr_bcd_low;
    logic [7:0]            hr_dec;
    logic [6:0]            hr12_base;
    logic [7:0]            hr12;
    logic [7:0]            day_dec;
    logic [7:0]            mon_dec;
    logic [7:0]            yr_dec;
    logic [7:0]            cen_dec;
    logic [14:0]           cen_full;
    logic [14:0]           piv_base;
    logic [14:0]           piv_full;
    logic [14:0]           full_year;

    logic [12:0]           leaps;
    logic [13:0]           years;
    logic [21:0]           days_years;
    logic [13:0]           rem100;
    logic                  leap;

    logic [39:0]           secs_total;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            century_present_reg <= CENTURY_PRESENT_RST;
            pivot_year_reg      <= PIVOT_YEAR_RST;
            pivot_century_reg   <= PIVOT_CENTURY_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_CENTURY_PRESENT:
                begin
                    century_present_reg <= pwdata[0];
                end
                REG_PIVOT_YEAR:
                begin
                    pivot_year_reg    <= pwdata[13:0];
                    pivot_century_reg <= div100(pwdata[13:0]);
                end
                default:
                begin
                    century_present_reg <= century_present_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_CENTURY_PRESENT: prdata = CFG_DATA_W'(century_present_reg);
            REG_PIVOT_YEAR:      prdata = CFG_DATA_W'(pivot_year_reg);
            default:             prdata = '0;
        endcase
    end

    // Pipeline flow control.
    always_comb
    begin
        stage_ready[NUM_STAGES-1] = !stage_valid_reg[NUM_STAGES-1] || result_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !stage_valid_reg[k] || stage_ready[k+1];
        end
        stage_valid_next = stage_valid_reg;
        if (stage_ready[0])
        begin
            stage_valid_next[0] = snap_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (stage_ready[k])
            begin
                stage_valid_next[k] = stage_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    assign snap_ready   = stage_ready[0];
    assign result_valid = stage_valid_reg[NUM_STAGES-1];
    assign result       = result_reg;

    // Decode: BCD, 12-hour clock and full year.
    always_comb
    begin
        sec_dec    = snap_reg.binary_mode ? snap_reg.raw_seconds : from_bcd(snap_reg.raw_seconds);
        min_dec    = snap_reg.binary_mode ? snap_reg.raw_minutes : from_bcd(snap_reg.raw_minutes);
        day_dec    = snap_reg.binary_mode ? snap_reg.raw_day     : from_bcd(snap_reg.raw_day);
        mon_dec    = snap_reg.binary_mode ? snap_reg.raw_month   : from_bcd(snap_reg.raw_month);
        yr_dec     = snap_reg.binary_mode ? snap_reg.raw_year    : from_bcd(snap_reg.raw_year);
        cen_dec    = snap_reg.binary_mode ? snap_reg.raw_century : from_bcd(snap_reg.raw_century);
        hr_bcd_low = from_bcd({1'b0, snap_reg.raw_hours[6:0]});
        hr_dec     = snap_reg.binary_mode ? snap_reg.raw_hours
                                          : {snap_reg.raw_hours[7], hr_bcd_low[6:0]};
        hr12_base  = (hr_dec[6:0] == 7'd12) ? 7'd0 : hr_dec[6:0];
        hr12       = {1'b0, hr12_base} + (hr_dec[7] ? 8'd12 : 8'd0);

        cen_full   = 15'(yr_dec) + 15'(cen_dec) * 15'd100;
        piv_base   = 15'(yr_dec) + 15'(pivot_century_reg) * 15'd100;
        piv_full   = (piv_base < 15'(pivot_year_reg)) ? piv_base + 15'd100 : piv_base;
        full_year  = century_present_reg ? cen_full : piv_full;

        decode_next.sec       = sec_dec;
        decode_next.min       = min_dec;
        decode_next.hr        = snap_reg.mode_24h ? hr_dec : hr12;
        decode_next.day_off   = (day_dec == 8'd0) ? 8'd0 : day_dec - 8'd1;
        decode_next.range_err = (mon_dec == 8'd0) || (mon_dec > 8'd12) || (full_year > MAX_YEAR);
        decode_next.mon_idx   = decode_next.range_err ? 4'd11 : mon_dec[3:0] - 4'd1;
        decode_next.mon_gt2   = mon_dec > 8'd2;
        decode_next.full      = full_year;
        decode_next.year_out  = (full_year > MAX_YEAR) ? MAX_YEAR[13:0] : full_year[13:0];
        decode_next.pre_epoch = full_year < EPOCH_YEAR;
    end

    // Quotients by 100 and time of day.
    always_comb
    begin
        quot_next.y_m1      = 14'(decode_reg.full - 15'd1);
        quot_next.q_y       = div100(quot_next.y_m1);
        quot_next.q_f       = div100(decode_reg.full[13:0]);
        quot_next.tod       = 20'(decode_reg.hr) * 20'(SECS_PER_HOUR)
                            + 20'(decode_reg.min) * 20'd60
                            + 20'(decode_reg.sec);
        quot_next.day_off   = decode_reg.day_off;
        quot_next.mon_idx   = decode_reg.mon_idx;
        quot_next.mon_gt2   = decode_reg.mon_gt2;
        quot_next.full      = decode_reg.full;
        quot_next.year_out  = decode_reg.year_out;
        quot_next.pre_epoch = decode_reg.pre_epoch;
        quot_next.range_err = decode_reg.range_err;
    end

    // Day count from the epoch with the Gregorian leap rules.
    always_comb
    begin
        leaps      = 13'(quot_reg.y_m1[13:2]) - 13'(quot_reg.q_y) + 13'(quot_reg.q_y[7:2]);
        years      = 14'(quot_reg.full - EPOCH_YEAR);
        days_years = 22'(years) * 22'd365 + 22'(leaps) - LEAPS_BEFORE_EPOCH;
        rem100     = quot_reg.full[13:0] - 14'(quot_reg.q_f) * 14'd100;
        leap       = ((quot_reg.full[1:0] == 2'd0) && (rem100 != 14'd0))
                  || ((rem100 == 14'd0) && (quot_reg.q_f[1:0] == 2'd0));

        days_next.days      = ((quot_reg.full > EPOCH_YEAR) ? days_years : 22'd0)
                            + 22'(month_start(quot_reg.mon_idx))
                            + 22'(quot_reg.mon_gt2 && leap)
                            + 22'(quot_reg.day_off);
        days_next.tod       = quot_reg.tod;
        days_next.year_out  = quot_reg.year_out;
        days_next.pre_epoch = quot_reg.pre_epoch;
        days_next.range_err = quot_reg.range_err;
    end

    // Seconds and saturation.
    always_comb
    begin
        secs_total = 40'(days_reg.days) * 40'(SECS_PER_DAY) + 40'(days_reg.tod);

        result_next.unix_seconds = (days_reg.range_err || (secs_total > 40'(MAX_UNIX)))
                                 ? MAX_UNIX : secs_total[37:0];
        result_next.full_year    = days_reg.year_out;
        result_next.before_epoch = days_reg.pre_epoch;
        result_next.range_error  = days_reg.range_err;
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            snap_reg <= snap;
        end
        if (stage_ready[1])
        begin
            decode_reg <= decode_next;
        end
        if (stage_ready[2])
        begin
            quot_reg <= quot_next;
        end
        if (stage_ready[3])
        begin
            days_reg <= days_next;
        end
        if (stage_ready[4])
        begin
            result_reg <= result_next;
        end
    end

    `ASSERT_IMPLY(a_range_saturates, clk, rst_n, result_valid && result.range_error, result.unix_seconds == MAX_UNIX)
    `ASSERT_IMPLY(a_seconds_bounded, clk, rst_n, result_valid, result.unix_seconds <= MAX_UNIX)
    `ASSERT_IMPLY(a_before_epoch_year, clk, rst_n, result_valid && result.before_epoch, 15'(result.full_year) < EPOCH_YEAR)
    `ASSERT_HOLD(a_pivot_century, clk, rst_n, (15'(pivot_century_reg) * 15'd100 <= 15'(pivot_year_reg)) && (15'(pivot_year_reg) < 15'(pivot_century_reg) * 15'd100 + 15'd100))

endmodule

`default_nettype wire

### dv/cmos_rtc_to_unix_time_tb.sv
// Testbench for cmos_rtc_to_unix_time: random and directed clock snapshots with random stalls,
// checked beat by beat against a timestamp predictor kept in this file.
// Depends on rtc2unix_pkg and the cmos_rtc_to_unix_time RTL.
`timescale 1ns / 1ps

module cmos_rtc_to_unix_time_tb;

    import rtc2unix_pkg::*;

    localparam int unsigned         FIRST_YEAR  = 1970;
    localparam int unsigned         YEAR_LIMIT  = 9999;
    localparam longint unsigned     UNIX_LIMIT  = 64'd253402300799;
    localparam int unsigned         HOLD_CYCLES = 150;
    localparam logic [11:0][8:0]    MONTH_OFFSET = {9'd334, 9'd304, 9'd273, 9'd243, 9'd212,
        9'd181, 9'd151, 9'd120, 9'd90, 9'd59, 9'd31, 9'd0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  snap_valid = 1'b0;
    logic                  snap_ready;
    snap_t                 snap = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  cfg_century_present = CENTURY_PRESENT_RST;
    logic [13:0]           cfg_pivot_year = PIVOT_YEAR_RST;

    snap_t                 pending_snaps[$];
    result_t               expected_results[$];
    result_t               oldest_expected;
    logic                  snap_fired = 1'b0;
    logic                  result_fired = 1'b0;
    logic                  send_burst = 1'b0;
    logic                  recv_burst = 1'b0;
    int unsigned           send_gap = 0;
    int unsigned           stall_left = 0;
    int unsigned           hold_req = 0;
    int unsigned           hold_seen = 0;
    int unsigned           fail_count = 0;

    cmos_rtc_to_unix_time DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (snap_valid),
        .snap_ready   (snap_ready),
        .snap         (snap),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    function automatic int unsigned bcd_value(input logic [7:0] b);
        return 32'(b[3:0]) + 32'(b[7:4]) * 10;
    endfunction

    function automatic longint unsigned leaps_through(input int unsigned y);
        return longint'(y / 4) - longint'(y / 100) + longint'(y / 400);
    endfunction

    function automatic result_t predict_timestamp(input snap_t s);
        int unsigned     second;
        int unsigned     minute;
        int unsigned     hour;
        int unsigned     hour12;
        int unsigned     day;
        int unsigned     month;
        int unsigned     yr2;
        int unsigned     century;
        int unsigned     full_yr;
        longint unsigned days;
        longint unsigned stamp;
        logic            bad;
        result_t         r;
        second  = s.raw_seconds;
        minute  = s.raw_minutes;
        hour    = s.raw_hours;
        day     = s.raw_day;
        month   = s.raw_month;
        yr2     = s.raw_year;
        century = s.raw_century;
        if (!s.binary_mode)
        begin
            second  = bcd_value(s.raw_seconds);
            minute  = bcd_value(s.raw_minutes);
            hour    = bcd_value({1'b0, s.raw_hours[6:0]}) | (hour & 32'h80);
            day     = bcd_value(s.raw_day);
            month   = bcd_value(s.raw_month);
            yr2     = bcd_value(s.raw_year);
            century = bcd_value(s.raw_century);
        end
        if (!s.mode_24h)
        begin
            hour12 = hour & 32'h7F;
            if (hour12 == 12)
                hour12 = 0;
            if (hour[7])
                hour12 += 12;
            hour = hour12;
        end
        if (cfg_century_present)
        begin
            full_yr = yr2 + century * 100;
        end
        else
        begin
            full_yr = yr2 + (32'(cfg_pivot_year) / 100) * 100;
            if (full_yr < 32'(cfg_pivot_year))
                full_yr += 100;
        end
        bad = (month < 1) || (month > 12) || (full_yr > YEAR_LIMIT);
        if (bad)
        begin
            stamp = UNIX_LIMIT;
        end
        else
        begin
            days = 0;
            if (full_yr > FIRST_YEAR)
                days = 365 * longint'(full_yr - FIRST_YEAR) + leaps_through(full_yr - 1)
                     - leaps_through(FIRST_YEAR - 1);
            days += MONTH_OFFSET[month - 1];
            if (month > 2 && ((full_yr % 400 == 0) || (full_yr % 4 == 0 && full_yr % 100 != 0)))
                days += 1;
            if (day > 0)
                days += day - 1;
            stamp = days * 86400 + longint'(hour) * 3600 + longint'(minute) * 60
                  + longint'(second);
            if (stamp > UNIX_LIMIT)
                stamp = UNIX_LIMIT;
        end
        r.unix_seconds = stamp[37:0];
        r.full_year    = (full_yr > YEAR_LIMIT) ? 14'(YEAR_LIMIT) : 14'(full_yr);
        r.before_epoch = full_yr < FIRST_YEAR;
        r.range_error  = bad;
        return r;
    endfunction

    function automatic snap_t snapshot(input logic [7:0] second, input logic [7:0] minute,
                                       input logic [7:0] hour, input logic [7:0] day,
                                       input logic [7:0] month, input logic [7:0] yr2,
                                       input logic [7:0] century, input logic binary,
                                       input logic h24);
        snap_t s;
        s.raw_seconds = second;
        s.raw_minutes = minute;
        s.raw_hours   = hour;
        s.raw_day     = day;
        s.raw_month   = month;
        s.raw_year    = yr2;
        s.raw_century = century;
        s.binary_mode = binary;
        s.mode_24h    = h24;
        return s;
    endfunction

    function automatic logic [7:0] field_byte(input int unsigned v, input logic binary);
        if (binary)
            return 8'(v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic snap_t random_snapshot();
        snap_t       s;
        logic [7:0]  noise;
        int unsigned century;
        s.binary_mode = 1'($urandom_range(0, 1));
        s.mode_24h    = 1'($urandom_range(0, 1));
        s.raw_seconds = field_byte($urandom_range(0, 59), s.binary_mode);
        s.raw_minutes = field_byte($urandom_range(0, 59), s.binary_mode);
        if (s.mode_24h)
            s.raw_hours = field_byte($urandom_range(0, 23), s.binary_mode);
        else
            s.raw_hours = field_byte($urandom_range(1, 12), s.binary_mode)
                        | {1'($urandom_range(0, 1)), 7'd0};
        s.raw_day   = field_byte(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 31),
                                 s.binary_mode);
        s.raw_month = field_byte($urandom_range(1, 12), s.binary_mode);
        s.raw_year  = field_byte($urandom_range(0, 99), s.binary_mode);
        century     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 99)
                                                  : $urandom_range(19, 21);
        s.raw_century = field_byte(century, s.binary_mode);
        if ($urandom_range(0, 3) == 0)
        begin
            noise = 8'($urandom);
            if (noise[0]) s.raw_seconds = 8'($urandom);
            if (noise[1]) s.raw_minutes = 8'($urandom);
            if (noise[2]) s.raw_hours   = 8'($urandom);
            if (noise[3]) s.raw_day     = 8'($urandom);
            if (noise[4]) s.raw_month   = 8'($urandom);
            if (noise[5]) s.raw_year    = 8'($urandom);
            if (noise[6]) s.raw_century = 8'($urandom);
        end
        return s;
    endfunction

    function automatic int unsigned draw_gap(input logic burst);
        return burst ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        snap_fired <= rst_n && snap_valid && snap_ready;
        if (rst_n && snap_valid && snap_ready)
            expected_results.push_back(predict_timestamp(snap));
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            snap_valid <= 1'b0;
        end
        else if (!snap_valid || snap_fired)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                snap_valid <= 1'b0;
            end
            else if (pending_snaps.size() > 0)
            begin
                snap       <= pending_snaps.pop_front();
                snap_valid <= 1'b1;
                send_gap = draw_gap(send_burst);
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
            end
            else
            begin
                snap_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        result_fired <= rst_n && result_valid && result_ready;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat with none expected, expected nothing, got %0d",
                         $time, result.unix_seconds);
                fail_count++;
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                check_field("unix_seconds", oldest_expected.unix_seconds, result.unix_seconds);
                check_field("full_year", oldest_expected.full_year, result.full_year);
                check_field("before_epoch", oldest_expected.before_epoch, result.before_epoch);
                check_field("range_error", oldest_expected.range_error, result.range_error);
            end
        end
    end

    always @(negedge clk)
    begin
        if (result_fired)
        begin
            stall_left = draw_gap(recv_burst);
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
        end
        if (hold_req != hold_seen)
        begin
            hold_seen  = hold_req;
            stall_left = HOLD_CYCLES;
        end
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    task automatic drain_results();
        while (pending_snaps.size() != 0 || snap_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_config(input logic [0:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] mask;
        mask = (idx == REG_CENTURY_PRESENT) ? 32'h1 : 32'h3FFF;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (idx == REG_CENTURY_PRESENT)
            cfg_century_present = value[0];
        else
            cfg_pivot_year = value[13:0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        check_field("register readback", value & mask, readback & mask);
    endtask

    task automatic set_config(input logic century_present, input int unsigned pivot);
        write_config(REG_CENTURY_PRESENT, 32'(century_present));
        write_config(REG_PIVOT_YEAR, pivot);
    endtask

    task automatic run_random(input int unsigned count);
        repeat (count) pending_snaps.push_back(random_snapshot());
        drain_results();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_snaps.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1));
        pending_snaps.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h25, 8'h00, 0, 1));
        pending_snaps.push_back(snapshot(8'h30, 8'h45, 8'h12, 8'h15, 8'h06, 8'h25, 8'h00, 0, 0));
        pending_snaps.push_back(snapshot(8'h30, 8'h45, 8'h92, 8'h15, 8'h06, 8'h25, 8'h00, 0, 0));
        pending_snaps.push_back(snapshot(8'h00, 8'h01, 8'h81, 8'h15, 8'h06, 8'h25, 8'h00, 0, 0));
        pending_snaps.push_back(snapshot(8'h59, 8'h59, 8'h11, 8'h15, 8'h06, 8'h25, 8'h00, 0, 0));
        pending_snaps.push_back(snapshot(8'h10, 8'h20, 8'h95, 8'h10, 8'h10, 8'h30, 8'h00, 0, 1));
        pending_snaps.push_back(snapshot(8'h10, 8'h20, 8'h05, 8'h00, 8'h03, 8'h40, 8'h00, 0, 1));
        pending_snaps.push_back(snapshot(8'h10, 8'h20, 8'h05, 8'h10, 8'h13, 8'h40, 8'h00, 0, 1));
        pending_snaps.push_back(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 1));
        pending_snaps.push_back(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0));
        pending_snaps.push_back(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 1));
        pending_snaps.push_back(snapshot(8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h24, 8'h00, 0, 1));
        pending_snaps.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h24, 8'h00, 0, 1));
        pending_snaps.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 0, 1));
        pending_snaps.push_back(snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h00, 0, 1));
        pending_snaps.push_back(snapshot(8'd5, 8'd6, 8'h8C, 8'd7, 8'd8, 8'd50, 8'd0, 1, 0));
        pending_snaps.push_back(snapshot(8'h00, 8'h00, 8'h9F, 8'h01, 8'h01, 8'h50, 8'h00, 0, 0));
        run_random(100);

        set_config(1'b1, 2025);
        pending_snaps.push_back(snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69, 8'h19, 0, 1));
        pending_snaps.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19, 0, 1));
        pending_snaps.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h20, 0, 1));
        pending_snaps.push_back(snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h99, 0, 1));
        pending_snaps.push_back(snapshot(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd100, 1, 1));
        pending_snaps.push_back(snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00, 0, 1));
        pending_snaps.push_back(snapshot(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h05, 8'hFF, 8'hFF, 1, 1));
        run_random(150);

        set_config(1'b0, 1970);
        run_random(150);

        set_config(1'b0, 9899);
        hold_req++;
        run_random(150);

        set_config(1'b1, 9899);
        run_random(75);
        run_random(75);

        set_config(1'b0, $urandom_range(1970, 9899));
        run_random(150);

        set_config(1'b1, 1970);
        run_random(150);

        set_config(1'b0, 2025);
        run_random(200);

        if (fail_count == 0)
            $display("cmos_rtc_to_unix_time_tb OK");
        else
            $display("cmos_rtc_to_unix_time_tb NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("cmos_rtc_to_unix_time_tb NOT OK");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/rtc2unix_pkg.sv
hdl/cmos_rtc_to_unix_time.sv
dv/cmos_rtc_to_unix_time_tb.sv
